// File: rtl/tdlm_pkg.sv
// ---------------------------------------------------------------------------
// tdlm_pkg
// Shared types and constants for the delta-list timer manager.
// ---------------------------------------------------------------------------
package tdlm_pkg;

    localparam int NSLOT = 32;
    localparam int SW    = $clog2(NSLOT);
    localparam int CW    = $clog2(NSLOT + 1);

    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_ADD   = 3'd1;
    localparam logic [2:0] REQ_DEL   = 3'd2;
    localparam logic [2:0] REQ_START = 3'd3;
    localparam logic [2:0] REQ_STOP  = 3'd4;
    localparam logic [2:0] REQ_RESET = 3'd5;
    localparam logic [2:0] REQ_READ  = 3'd6;

    localparam int FL_STOP = 0;
    localparam int FL_EXP  = 1;
    localparam int FL_ONE  = 2;
    localparam int FL_DEL  = 3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_DEC,
        CELL_INS,
        CELL_REM
    } t_cell_op;

    typedef struct packed {
        t_cell_op        op;
        logic [SW-1:0]   pos;
        logic [SW-1:0]   slot;
        logic [31:0]     delta;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DISP,
        ST_TK_CHK,
        ST_TK_EMIT,
        ST_ADD_SRCH,
        ST_ADD_DIV,
        ST_INS,
        ST_WALK,
        ST_DEL_FIN,
        ST_START_FIN,
        ST_STOP_FIN,
        ST_RS_POST,
        ST_RS_DIV,
        ST_EMIT
    } t_state;

endpackage

// File: rtl/tdlm_cell.sv
// ---------------------------------------------------------------------------
// tdlm_cell
// One position of the active list: slot number and ticks beyond the
// previous entry. Shifts with its neighbors on insert and remove.
// ---------------------------------------------------------------------------
module tdlm_cell (
    input  logic                     i_clk,
    input  logic [tdlm_pkg::SW-1:0]  i_idx,
    input  tdlm_pkg::t_cell_ctl      i_ctl,
    input  logic [tdlm_pkg::SW-1:0]  i_left_slot,
    input  logic [31:0]              i_left_delta,
    input  logic [tdlm_pkg::SW-1:0]  i_right_slot,
    input  logic [31:0]              i_right_delta,
    output logic [tdlm_pkg::SW-1:0]  o_slot,
    output logic [31:0]              o_delta
);
    import tdlm_pkg::*;

    logic [SW-1:0] r_slot;
    logic [31:0]   r_delta;
    logic          is_next;

    assign is_next = ({1'b0, i_idx} == ({1'b0, i_ctl.pos} + 1'b1));

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            CELL_DEC: begin
                if (i_idx == '0) begin
                    r_delta <= r_delta - 32'd1;
                end
            end
            CELL_INS: begin
                if (i_idx == i_ctl.pos) begin
                    r_slot  <= i_ctl.slot;
                    r_delta <= i_ctl.delta;
                end else if (i_idx > i_ctl.pos) begin
                    r_slot  <= i_left_slot;
                    r_delta <= is_next ? i_left_delta - i_ctl.delta : i_left_delta;
                end
            end
            CELL_REM: begin
                if (i_idx == i_ctl.pos) begin
                    r_slot  <= i_right_slot;
                    r_delta <= i_right_delta + r_delta;
                end else if (i_idx > i_ctl.pos) begin
                    r_slot  <= i_right_slot;
                    r_delta <= i_right_delta;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_slot  = r_slot;
    assign o_delta = r_delta;

endmodule

// File: rtl/tdlm_div.sv
// ---------------------------------------------------------------------------
// tdlm_div
// Bit-serial divider: milliseconds to ticks, rounded up. 32 steps.
// ---------------------------------------------------------------------------
module tdlm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [9:0]  i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [9:0]  r_r;
    logic [9:0]  r_div;
    logic [10:0] trial;
    logic        fits;

    assign trial = {r_r, r_q[31]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_r    <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_r   <= fits ? 10'(trial - {1'b0, r_div}) : trial[9:0];
                r_q   <= {r_q[30:0], fits};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q + {31'd0, (r_r != '0)};

endmodule

// File: rtl/delta_list_timer_manager_unit.sv
// ---------------------------------------------------------------------------
// delta_list_timer_manager_unit
// Pool of 32 software timers kept in a delta-sorted active list.
// ---------------------------------------------------------------------------
// One word is taken at a time. Each word first passes accept and setup
// (elapsed time multiply in two 32x10 halves). A list search and an
// insertion walk the row of list cells one position a cycle. Add scans up
// to 32 slots, one a cycle, and add and reset with a new duration wait on
// the serial divider. A tick decrements a nonzero head delta, then sends an
// expiry notice for each head entry at zero and, for each expiring periodic
// timer, does one insertion walk. Output words wait in an output register.
// ---------------------------------------------------------------------------
module delta_list_timer_manager_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [9:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_timer_id,
    input  logic [31:0] i_duration_ms,
    input  logic        i_one_shot,
    input  logic        i_delete_on_expiry,
    input  logic        i_start_stopped,
    input  logic [7:0]  i_user_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic        o_ok,
    output logic [15:0] o_result_id,
    output logic [7:0]  o_notice_cmd,
    output logic [31:0] o_read_duration_ms,
    output logic        o_read_stopped,
    output logic        o_read_expired,
    output logic        o_read_one_shot,
    output logic        o_read_delete_flag,
    output logic [63:0] o_elapsed_ms,
    output logic        o_last
);
    import tdlm_pkg::*;

    // slot store
    logic [31:0] r_dur [NSLOT];
    logic [31:0] r_per [NSLOT];
    logic [31:0] r_rem [NSLOT];
    logic [3:0]  r_flg [NSLOT];
    logic [7:0]  r_cmd [NSLOT];

    // list cells
    logic [SW-1:0] c_slot  [NSLOT];
    logic [31:0]   c_delta [NSLOT];
    logic [SW-1:0] l_slot  [NSLOT];
    logic [31:0]   l_delta [NSLOT];
    logic [SW-1:0] g_slot  [NSLOT];
    logic [31:0]   g_delta [NSLOT];
    t_cell_ctl     cell_ctl;

    t_state r_state, n_state, r_ret, n_ret;
    logic [2:0]    r_req;
    logic [15:0]   r_id;
    logic [31:0]   r_din;
    logic          r_one, r_del, r_stp;
    logic [7:0]    r_ucmd;
    logic [SW-1:0] r_s, n_s;
    logic [CW-1:0] r_i, n_i;
    logic [31:0]   r_d, n_d;
    logic [SW-1:0] r_k, n_k;
    logic          r_ok, n_ok;
    logic [15:0]   r_rid, n_rid;
    logic          r_show, n_show;
    logic          r_found, n_found;
    logic          r_rm_en, n_rm_en;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [63:0]   r_tt, n_tt;
    logic [63:0]   r_el, n_el;
    logic [SW-1:0] r_last_alloc, n_last_alloc;
    logic [9:0]    r_period;

    logic          r_o_valid, r_o_kind, r_o_ok, r_o_last;
    logic [15:0]   r_o_id;
    logic [7:0]    r_o_cmd;
    logic [31:0]   r_o_rdur;
    logic [3:0]    r_o_flg;
    logic [63:0]   r_o_el;

    // output load
    logic          ld_out, ld_kind, ld_ok, ld_last;
    logic [15:0]   ld_id;
    logic [7:0]    ld_cmd;
    logic [31:0]   ld_rdur;
    logic [3:0]    ld_flg;

    // slot writes, all at r_s
    logic          we_dur, we_per, we_rem, we_flg, we_cmd;
    logic [31:0]   wd_dur, wd_per, wd_rem;
    logic [3:0]    wd_flg;

    logic          div_start, div_done;
    logic [31:0]   div_quot;
    logic [9:0]    eff;
    logic [41:0]   mul_prod;
    logic          ofree, id_ok, alloc;
    logic [SW-1:0] cur_slot;
    logic [31:0]   cur_delta, walk_sum;
    logic          in_range;

    assign eff      = (r_period == '0) ? 10'd1 : r_period;
    assign mul_prod = {10'd0, (r_state == ST_MUL_LO) ? r_tt[31:0] : r_tt[63:32]}
                      * {32'd0, eff};
    assign ofree    = !r_o_valid || i_ready;
    assign id_ok    = (r_id != 16'd0) && (r_id <= 16'(NSLOT));
    assign alloc    = id_ok && (r_dur[r_s] != '0);
    assign cur_slot  = c_slot[r_i[SW-1:0]];
    assign cur_delta = c_delta[r_i[SW-1:0]];
    assign walk_sum  = r_d + cur_delta;
    assign in_range  = r_i < r_cnt;

    tdlm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_din),
        .i_divisor  (eff),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    for (genvar g = 0; g < NSLOT; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign l_slot[g]  = '0;
            assign l_delta[g] = '0;
        end else begin : g_mid_l
            assign l_slot[g]  = c_slot[g-1];
            assign l_delta[g] = c_delta[g-1];
        end
        if (g == NSLOT - 1) begin : g_end
            assign g_slot[g]  = '0;
            assign g_delta[g] = '0;
        end else begin : g_mid_r
            assign g_slot[g]  = c_slot[g+1];
            assign g_delta[g] = c_delta[g+1];
        end
        tdlm_cell u_cell (
            .i_clk         (i_clk),
            .i_idx         (SW'(g)),
            .i_ctl         (cell_ctl),
            .i_left_slot   (l_slot[g]),
            .i_left_delta  (l_delta[g]),
            .i_right_slot  (g_slot[g]),
            .i_right_delta (g_delta[g]),
            .o_slot        (c_slot[g]),
            .o_delta       (c_delta[g])
        );
    end

    always_comb begin
        n_state = r_state;  n_ret = r_ret;   n_s = r_s;     n_i = r_i;
        n_d = r_d;          n_k = r_k;       n_ok = r_ok;   n_rid = r_rid;
        n_show = r_show;    n_found = r_found; n_rm_en = r_rm_en;
        n_cnt = r_cnt;      n_tt = r_tt;     n_el = r_el;
        n_last_alloc = r_last_alloc;
        cell_ctl = '{op: CELL_HOLD, pos: r_i[SW-1:0], slot: r_s, delta: r_d};
        ld_out = 1'b0; ld_kind = 1'b0; ld_ok = 1'b0; ld_last = 1'b0;
        ld_id = r_rid; ld_cmd = '0; ld_rdur = '0; ld_flg = '0;
        we_dur = 1'b0; we_per = 1'b0; we_rem = 1'b0; we_flg = 1'b0; we_cmd = 1'b0;
        wd_dur = r_din; wd_per = div_quot; wd_rem = div_quot; wd_flg = r_flg[r_s];
        div_start = 1'b0;
        o_ready = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MUL_LO;
                    n_s     = SW'(i_timer_id[SW-1:0] - 1'b1);
                    n_ok    = 1'b0;
                    n_rid   = i_timer_id;
                    n_show  = 1'b0;
                    n_i     = '0;
                    n_d     = '0;
                    n_found = 1'b0;
                    if (i_req_type == REQ_TICK) begin
                        n_tt = r_tt + 64'd1;
                    end
                end
            end
            ST_MUL_LO: begin
                n_el    = {22'd0, mul_prod};
                n_state = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                n_el    = r_el + {mul_prod[31:0], 32'd0};
                n_state = ST_DISP;
            end
            ST_DISP: begin
                n_state = ST_EMIT;
                n_ret   = ST_EMIT;
                unique case (r_req)
                    REQ_TICK: begin
                        n_ok = 1'b1;
                        if (r_cnt != '0 && c_delta[0] != '0) begin
                            cell_ctl.op = CELL_DEC;
                        end
                        n_state = ST_TK_CHK;
                    end
                    REQ_ADD: begin
                        n_rid = '0;
                        n_s   = r_last_alloc + 1'b1;
                        n_k   = '0;
                        if (r_din != '0) begin
                            n_state = ST_ADD_SRCH;
                        end
                    end
                    REQ_DEL: begin
                        if (alloc) begin
                            n_rm_en = 1'b1;
                            n_ret   = ST_DEL_FIN;
                            n_state = ST_WALK;
                        end
                    end
                    REQ_START: begin
                        if (alloc && !(r_flg[r_s][FL_EXP] && r_flg[r_s][FL_ONE])) begin
                            n_rm_en = 1'b0;
                            n_ret   = ST_START_FIN;
                            n_state = ST_WALK;
                        end
                    end
                    REQ_STOP: begin
                        if (alloc) begin
                            n_rm_en = 1'b1;
                            n_ret   = ST_STOP_FIN;
                            n_state = ST_WALK;
                        end
                    end
                    REQ_RESET: begin
                        if (alloc) begin
                            n_rm_en = 1'b1;
                            n_ret   = ST_RS_POST;
                            n_state = ST_WALK;
                        end
                    end
                    REQ_READ: begin
                        n_ok   = id_ok;
                        n_show = id_ok;
                    end
                    default: begin
                    end
                endcase
            end
            ST_TK_CHK: begin
                if (r_cnt != '0 && c_delta[0] == '0) begin
                    n_s         = c_slot[0];
                    cell_ctl.op = CELL_REM;
                    cell_ctl.pos = '0;
                    n_cnt       = r_cnt - 1'b1;
                    n_state     = ST_TK_EMIT;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_TK_EMIT: begin
                if (ofree) begin
                    ld_out  = 1'b1;
                    ld_kind = 1'b1;
                    ld_ok   = 1'b1;
                    ld_id   = 16'(r_s) + 16'd1;
                    ld_cmd  = r_cmd[r_s];
                    if (r_flg[r_s][FL_ONE]) begin
                        we_flg = 1'b1;
                        wd_flg = r_flg[r_s] | 4'b0011;
                        we_rem = 1'b1;
                        wd_rem = r_per[r_s];
                        if (r_flg[r_s][FL_DEL]) begin
                            we_dur = 1'b1;
                            wd_dur = '0;
                        end
                        n_state = ST_TK_CHK;
                    end else begin
                        n_d     = r_per[r_s];
                        n_i     = '0;
                        n_ret   = ST_TK_CHK;
                        n_state = ST_INS;
                    end
                end
            end
            ST_ADD_SRCH: begin
                if (r_dur[r_s] == '0) begin
                    div_start = 1'b1;
                    n_state   = ST_ADD_DIV;
                end else if (r_k == SW'(NSLOT - 1)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_s = r_s + 1'b1;
                    n_k = r_k + 1'b1;
                end
            end
            ST_ADD_DIV: begin
                if (div_done) begin
                    we_dur = 1'b1;
                    we_per = 1'b1;
                    we_rem = 1'b1;
                    we_cmd = 1'b1;
                    we_flg = 1'b1;
                    wd_flg = {r_del, r_one, 1'b0, r_stp};
                    n_last_alloc = r_s;
                    n_rid   = 16'(r_s) + 16'd1;
                    n_ok    = 1'b1;
                    n_d     = div_quot;
                    n_i     = '0;
                    n_ret   = ST_EMIT;
                    n_state = r_stp ? ST_EMIT : ST_INS;
                end
            end
            ST_INS: begin
                if (in_range && !(r_d < cur_delta)) begin
                    n_d = r_d - cur_delta;
                    n_i = r_i + 1'b1;
                end else begin
                    cell_ctl.op = CELL_INS;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = r_ret;
                end
            end
            ST_WALK: begin
                if (in_range) begin
                    if (cur_slot == r_s) begin
                        n_found = 1'b1;
                        if (r_rm_en) begin
                            cell_ctl.op = CELL_REM;
                            n_cnt  = r_cnt - 1'b1;
                            we_rem = 1'b1;
                            wd_rem = walk_sum;
                        end
                        n_state = r_ret;
                    end else begin
                        n_d = walk_sum;
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_state = r_ret;
                end
            end
            ST_DEL_FIN: begin
                we_dur  = 1'b1;
                wd_dur  = '0;
                n_ok    = 1'b1;
                n_state = ST_EMIT;
            end
            ST_START_FIN: begin
                n_ret = ST_EMIT;
                if (r_found) begin
                    n_state = ST_EMIT;
                end else begin
                    n_ok    = 1'b1;
                    we_flg  = 1'b1;
                    wd_flg  = r_flg[r_s] & ~4'b0001;
                    n_d     = r_rem[r_s];
                    n_i     = '0;
                    n_state = ST_INS;
                end
            end
            ST_STOP_FIN: begin
                if (r_found) begin
                    n_ok   = 1'b1;
                    we_flg = 1'b1;
                    wd_flg = r_flg[r_s] | 4'b0001;
                end
                n_state = ST_EMIT;
            end
            ST_RS_POST: begin
                n_ok   = 1'b1;
                n_i    = '0;
                n_ret  = ST_EMIT;
                we_flg = 1'b1;
                wd_flg = r_flg[r_s] & ~4'b0011;
                if (r_din != '0) begin
                    div_start = 1'b1;
                    n_state   = ST_RS_DIV;
                end else begin
                    n_d     = r_per[r_s];
                    n_state = ST_INS;
                end
            end
            ST_RS_DIV: begin
                if (div_done) begin
                    we_dur  = 1'b1;
                    we_per  = 1'b1;
                    n_d     = div_quot;
                    n_state = ST_INS;
                end
            end
            ST_EMIT: begin
                if (ofree) begin
                    ld_out  = 1'b1;
                    ld_ok   = r_ok;
                    ld_last = 1'b1;
                    if (r_show) begin
                        ld_cmd  = r_cmd[r_s];
                        ld_rdur = r_dur[r_s];
                        ld_flg  = r_flg[r_s];
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ret        <= ST_EMIT;
            r_cnt        <= '0;
            r_tt         <= '0;
            r_last_alloc <= SW'(NSLOT - 1);
            r_period     <= 10'd1;
            r_o_valid    <= 1'b0;
            for (int j = 0; j < NSLOT; j++) begin
                r_dur[j] <= '0;
                r_flg[j] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_cnt        <= n_cnt;
            r_tt         <= n_tt;
            r_last_alloc <= n_last_alloc;
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            if (ld_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (we_dur) begin
                r_dur[r_s] <= wd_dur;
            end
            if (we_flg) begin
                r_flg[r_s] <= wd_flg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_req  <= i_req_type;
            r_id   <= i_timer_id;
            r_din  <= i_duration_ms;
            r_one  <= i_one_shot;
            r_del  <= i_delete_on_expiry;
            r_stp  <= i_start_stopped;
            r_ucmd <= i_user_cmd;
        end
        r_s     <= n_s;
        r_i     <= n_i;
        r_d     <= n_d;
        r_k     <= n_k;
        r_ok    <= n_ok;
        r_rid   <= n_rid;
        r_show  <= n_show;
        r_found <= n_found;
        r_rm_en <= n_rm_en;
        r_el    <= n_el;
        if (we_per) begin
            r_per[r_s] <= wd_per;
        end
        if (we_rem) begin
            r_rem[r_s] <= wd_rem;
        end
        if (we_cmd) begin
            r_cmd[r_s] <= r_ucmd;
        end
        if (ld_out) begin
            r_o_kind <= ld_kind;
            r_o_ok   <= ld_ok;
            r_o_id   <= ld_id;
            r_o_cmd  <= ld_cmd;
            r_o_rdur <= ld_rdur;
            r_o_flg  <= ld_flg;
            r_o_el   <= r_el;
            r_o_last <= ld_last;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_kind             = r_o_kind;
    assign o_ok               = r_o_ok;
    assign o_result_id        = r_o_id;
    assign o_notice_cmd       = r_o_cmd;
    assign o_read_duration_ms = r_o_rdur;
    assign o_read_stopped     = r_o_flg[FL_STOP];
    assign o_read_expired     = r_o_flg[FL_EXP];
    assign o_read_one_shot    = r_o_flg[FL_ONE];
    assign o_read_delete_flag = r_o_flg[FL_DEL];
    assign o_elapsed_ms       = r_o_el;
    assign o_last             = r_o_last;

endmodule

// File: dv/delta_list_timer_manager_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// delta_list_timer_manager_unit_test
// Self-checking bench for the delta-list timer manager. A scoreboard class
// keeps its own timer pool and delta list, predicts the notice and status
// words for each accepted request word and checks the output words in order.
// Stimulus is a directed opening, then random request mixes under several
// tick periods, with random idling on both sides and one long output stall.
// ---------------------------------------------------------------------------
module delta_list_timer_manager_unit_test;
    import tdlm_pkg::*;

    localparam logic [2:0] REQ_BAD = 3'd7;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  req;
        logic [15:0] id;
        logic [31:0] dur;
        logic        one;
        logic        del;
        logic        stp;
        logic [7:0]  cmd;
    } t_req_word;

    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [15:0] id;
        logic [7:0]  cmd;
        logic [31:0] rdur;
        logic        rstop;
        logic        rexp;
        logic        rone;
        logic        rdel;
        logic [63:0] elapsed;
        logic        last;
    } t_res_word;

    class timer_pool_sb;
        bit [31:0]   dur_ms[NSLOT];
        bit [31:0]   per_tk[NSLOT];
        bit [31:0]   dlt_tk[NSLOT];
        bit [3:0]    flags[NSLOT];
        bit [7:0]    ucmd[NSLOT];
        bit          written[NSLOT];
        int          order[NSLOT];
        int          cnt = 0;
        bit [63:0]   ticks = 0;
        int          last_alloc = NSLOT - 1;
        bit [9:0]    period = 1;
        t_res_word   pending[$];
        int          errors = 0;
        int          words = 0;
        int          notices = 0;

        function bit [31:0] eff();
            return (period == 0) ? 32'd1 : {22'd0, period};
        endfunction

        function bit [31:0] to_ticks(bit [31:0] ms);
            bit [31:0] q;
            q = ms / eff();
            if (ms % eff() != 0) q++;
            return q;
        endfunction

        function void insert(int s);
            bit [31:0] d;
            int i;
            d = dlt_tk[s];
            i = 0;
            if (cnt >= NSLOT) return;
            while (i < cnt) begin
                if (d < dlt_tk[order[i]]) begin
                    dlt_tk[order[i]] -= d;
                    break;
                end
                d -= dlt_tk[order[i]];
                i++;
            end
            for (int k = cnt; k > i; k--) order[k] = order[k-1];
            order[i] = s;
            dlt_tk[s] = d;
            cnt++;
        endfunction

        function bit remove(int s);
            bit [31:0] rem;
            rem = 0;
            for (int i = 0; i < cnt; i++) begin
                rem += dlt_tk[order[i]];
                if (order[i] == s) begin
                    if (i + 1 < cnt) dlt_tk[order[i+1]] += dlt_tk[s];
                    for (int k = i; k + 1 < cnt; k++) order[k] = order[k+1];
                    cnt--;
                    dlt_tk[s] = rem;
                    return 1;
                end
            end
            return 0;
        endfunction

        function bit listed(int s);
            for (int i = 0; i < cnt; i++) if (order[i] == s) return 1;
            return 0;
        endfunction

        function void push(bit kind, bit ok, bit [15:0] id, bit [7:0] cmd, int s,
                           bit show, bit last);
            t_res_word r;
            r = '0;
            r.kind = kind;
            r.ok = ok;
            r.id = id;
            r.cmd = cmd;
            if (show) begin
                r.rdur = dur_ms[s];
                r.rstop = flags[s][FL_STOP];
                r.rexp = flags[s][FL_EXP];
                r.rone = flags[s][FL_ONE];
                r.rdel = flags[s][FL_DEL];
            end
            r.elapsed = ticks * {32'd0, eff()};
            r.last = last;
            pending.push_back(r);
        endfunction

        function void note_request(t_req_word w);
            bit vld, alloc, ok;
            int s, h, c;
            vld = (w.id >= 1 && w.id <= NSLOT);
            s = vld ? w.id - 1 : 0;
            alloc = vld && dur_ms[s] != 0;
            ok = 0;
            case (w.req)
                REQ_TICK: begin
                    ticks++;
                    if (cnt > 0 && dlt_tk[order[0]] > 0) dlt_tk[order[0]]--;
                    while (cnt > 0 && dlt_tk[order[0]] == 0) begin
                        h = order[0];
                        for (int k = 0; k + 1 < cnt; k++) order[k] = order[k+1];
                        cnt--;
                        push(1, 1, 16'(h + 1), ucmd[h], 0, 0, 0);
                        dlt_tk[h] = per_tk[h];
                        if (flags[h][FL_ONE]) begin
                            flags[h][FL_STOP] = 1;
                            flags[h][FL_EXP] = 1;
                            if (flags[h][FL_DEL]) dur_ms[h] = 0;
                        end else begin
                            insert(h);
                        end
                    end
                    push(0, 1, w.id, 0, 0, 0, 1);
                    return;
                end
                REQ_ADD: begin
                    int got;
                    got = 0;
                    if (w.dur != 0) begin
                        for (int i = 1; i <= NSLOT; i++) begin
                            c = (last_alloc + i) % NSLOT;
                            if (dur_ms[c] == 0) begin
                                dur_ms[c] = w.dur;
                                flags[c] = '0;
                                flags[c][FL_ONE] = w.one;
                                flags[c][FL_DEL] = w.del;
                                flags[c][FL_STOP] = w.stp;
                                ucmd[c] = w.cmd;
                                written[c] = 1;
                                per_tk[c] = to_ticks(w.dur);
                                dlt_tk[c] = per_tk[c];
                                if (!w.stp) insert(c);
                                last_alloc = c;
                                got = c + 1;
                                break;
                            end
                        end
                    end
                    push(0, got != 0, 16'(got), 0, 0, 0, 1);
                    return;
                end
                REQ_DEL: if (alloc) begin
                    void'(remove(s));
                    dur_ms[s] = 0;
                    ok = 1;
                end
                REQ_START: if (alloc && !listed(s) &&
                               !(flags[s][FL_EXP] && flags[s][FL_ONE])) begin
                    insert(s);
                    flags[s][FL_STOP] = 0;
                    ok = 1;
                end
                REQ_STOP: if (alloc && remove(s)) begin
                    flags[s][FL_STOP] = 1;
                    ok = 1;
                end
                REQ_RESET: if (alloc) begin
                    void'(remove(s));
                    if (w.dur != 0) begin
                        dur_ms[s] = w.dur;
                        per_tk[s] = to_ticks(w.dur);
                    end
                    dlt_tk[s] = per_tk[s];
                    insert(s);
                    flags[s][FL_STOP] = 0;
                    flags[s][FL_EXP] = 0;
                    ok = 1;
                end
                REQ_READ: if (vld) begin
                    push(0, 1, w.id, ucmd[s], s, 1, 1);
                    return;
                end
                default: ;
            endcase
            push(0, ok, w.id, 0, 0, 0, 1);
        endfunction

        function void check_result(t_res_word got);
            t_res_word exp;
            words++;
            if (got.kind === 1'b1) notices++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output word %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10) $display("mismatch at %0t\n  exp %p\n  got %p",
                                           $time, exp, got);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_wr_en = 0;
    logic [9:0]  i_cfg_wr_data = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [2:0]  i_req_type = 0;
    logic [15:0] i_timer_id = 0;
    logic [31:0] i_duration_ms = 0;
    logic        i_one_shot = 0;
    logic        i_delete_on_expiry = 0;
    logic        i_start_stopped = 0;
    logic [7:0]  i_user_cmd = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic        o_kind;
    logic        o_ok;
    logic [15:0] o_result_id;
    logic [7:0]  o_notice_cmd;
    logic [31:0] o_read_duration_ms;
    logic        o_read_stopped;
    logic        o_read_expired;
    logic        o_read_one_shot;
    logic        o_read_delete_flag;
    logic [63:0] o_elapsed_ms;
    logic        o_last;

    delta_list_timer_manager_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_timer_id(i_timer_id),
        .i_duration_ms(i_duration_ms), .i_one_shot(i_one_shot),
        .i_delete_on_expiry(i_delete_on_expiry), .i_start_stopped(i_start_stopped),
        .i_user_cmd(i_user_cmd),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_ok(o_ok), .o_result_id(o_result_id),
        .o_notice_cmd(o_notice_cmd), .o_read_duration_ms(o_read_duration_ms),
        .o_read_stopped(o_read_stopped), .o_read_expired(o_read_expired),
        .o_read_one_shot(o_read_one_shot), .o_read_delete_flag(o_read_delete_flag),
        .o_elapsed_ms(o_elapsed_ms), .o_last(o_last)
    );

    timer_pool_sb sb = new();
    bit   calm = 0;
    bit   rst_done = 0;
    int   n_requests = 0;
    int   quiet = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet <= 0;
        else if (rst_done) quiet <= quiet + 1;
        if (quiet > WDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // output side: random stalls and one long hold-off
    initial begin
        int  hold;
        bit  pressed;
        hold = 0;
        pressed = 0;
        wait (rst_done);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                sb.check_result({o_kind, o_ok, o_result_id, o_notice_cmd,
                                 o_read_duration_ms, o_read_stopped, o_read_expired,
                                 o_read_one_shot, o_read_delete_flag, o_elapsed_ms,
                                 o_last});
            if (hold > 0) begin
                hold--;
                i_ready <= 0;
            end else if (!pressed && sb.words >= 60) begin
                pressed = 1;
                hold = 400;
                i_ready <= 0;
            end else begin
                i_ready <= calm || ($urandom_range(99) >= 28);
            end
        end
    end

    task automatic send(t_req_word w);
        if (!calm && $urandom_range(99) < 28) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_req_type <= w.req;
        i_timer_id <= w.id;
        i_duration_ms <= w.dur;
        i_one_shot <= w.one;
        i_delete_on_expiry <= w.del;
        i_start_stopped <= w.stp;
        i_user_cmd <= w.cmd;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(w);
        n_requests++;
    endtask

    task automatic req(logic [2:0] r, logic [15:0] id, logic [31:0] dur = 0,
                       logic one = 0, logic del = 0, logic stp = 0, logic [7:0] cmd = 0);
        send({r, id, dur, one, del, stp, cmd});
    endtask

    task automatic set_period(logic [9:0] v);
        i_valid <= 0;
        wait (sb.pending.size() == 0);
        repeat (100) @(posedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        sb.period = v;
    endtask

    function automatic t_req_word rand_request(bit add_heavy);
        t_req_word w;
        int pick, sel;
        w.one = 1'($urandom_range(1));
        w.del = 1'($urandom_range(1));
        w.stp = ($urandom_range(99) < 15);
        w.cmd = 8'($urandom);
        pick = $urandom_range(99);
        if (add_heavy) w.req = (pick < 60) ? REQ_ADD : (pick < 85) ? REQ_TICK : REQ_READ;
        else if (pick < 40) w.req = REQ_TICK;
        else if (pick < 60) w.req = REQ_ADD;
        else if (pick < 97) w.req = 3'($urandom_range(2, 6));
        else w.req = REQ_BAD;
        sel = $urandom_range(99);
        if (sel < 85) w.dur = $urandom_range(1, 12 * sb.eff());
        else if (sel < 95) w.dur = $urandom;
        else w.dur = 0;
        sel = $urandom_range(99);
        if (sel < 80) w.id = 16'($urandom_range(1, NSLOT));
        else if (sel < 85) w.id = 0;
        else if (sel < 90) w.id = 16'(NSLOT + 1);
        else if (sel < 93) w.id = 16'hFFFF;
        else w.id = 16'($urandom);
        // never read a slot whose command byte was never set
        if (w.req == REQ_READ && w.id >= 1 && w.id <= NSLOT && !sb.written[w.id-1])
            w.id = 0;
        return w;
    endfunction

    initial begin
        logic [9:0] periods[6];
        periods = '{10'd1000, 10'd0, 10'd7, 10'd1023, 10'd3, 10'd1};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        rst_done = 1;

        // directed opening, period 1 from reset
        req(REQ_READ, 0);
        req(REQ_ADD, 5, 0);
        req(REQ_ADD, 5, 3, 1, 1, 0, 8'hFF);
        req(REQ_ADD, 9, 2, 0, 0, 0, 8'h00);
        req(REQ_ADD, 0, 32'hFFFF_FFFF, 1, 0, 1, 8'hA5);
        req(REQ_READ, 1);
        req(REQ_READ, 2);
        req(REQ_READ, 3);
        repeat (4) req(REQ_TICK, 16'hFFFF);
        req(REQ_START, 1);
        req(REQ_START, 3);
        req(REQ_START, 3);
        req(REQ_STOP, 3);
        req(REQ_STOP, 33);
        req(REQ_RESET, 2, 5);
        req(REQ_RESET, 2, 0);
        req(REQ_DEL, 1);
        req(REQ_RESET, 1, 4);
        req(REQ_READ, 1);
        req(REQ_DEL, 16'hFFFF);
        req(REQ_BAD, 2, 32'h8000_0001, 1, 1, 1, 8'h5A);

        foreach (periods[p]) begin
            set_period(periods[p]);
            for (int i = 0; i < 55; i++) begin
                calm = (p == 2 && i >= 10 && i < 45);
                send(rand_request(p == 1));
            end
            calm = 0;
        end

        i_valid <= 0;
        wait (sb.pending.size() == 0);
        repeat (200) @(posedge i_clk);
        sb.errors += sb.pending.size();
        $display("%0d requests over six tick periods, %0d output words, %0d expiry notices",
                 n_requests, sb.words, sb.notices);
        if (sb.errors > 0) $display("%0d mismatching words", sb.errors);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: delta_list_timer_manager_unit.f
rtl/tdlm_pkg.sv
rtl/tdlm_cell.sv
rtl/tdlm_div.sv
rtl/delta_list_timer_manager_unit.sv
dv/delta_list_timer_manager_unit_test.sv
